>>> hdl/lease_subscribe_broadcast_node_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lease subscribe broadcast node
// Shared forms for the concurrent checks in the RTL files.
// ----------------------------------------------------------------------------
`ifndef LEASE_SUBSCRIBE_BROADCAST_NODE_DEFINES_SVH
`define LEASE_SUBSCRIBE_BROADCAST_NODE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSBN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lsbn_pkg.sv
// ----------------------------------------------------------------------------
// lsbn_pkg
// Types, codes and defaults shared by the broadcast node modules.
// ----------------------------------------------------------------------------
package lsbn_pkg;

   localparam int PEER_SLOTS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT  = 32;

   localparam int ACTION_W     = 4;
   localparam int SLOT_FIELD_W = 4;
   localparam int NOW_W        = 32;
   localparam int KIND_W       = 3;
   localparam int TICKS_W      = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   // Lease length after reset: 10.0 s held as whole milliseconds.
   localparam logic [TICKS_W-1:0] LEASE_TICKS_RESET = 16'd10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRUNE_ON_DUPLICATE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEASE_TICKS       = 1'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUBLISH     = 4'd0,
      ACT_BODY_READY  = 4'd1,
      ACT_PEER_UPSERT = 4'd2,
      ACT_PEER_REMOVE = 4'd3,
      ACT_TIMER       = 4'd4,
      ACT_HAVE        = 4'd5,
      ACT_REQUEST     = 4'd6,
      ACT_PIECE       = 4'd7,
      ACT_CANCEL      = 4'd8,
      ACT_NEW_ROUND   = 4'd9
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DELIVER = 3'd0,
      KIND_PIECE   = 3'd1,
      KIND_HAVE    = 3'd2,
      KIND_REQUEST = 3'd3,
      KIND_CANCEL  = 3'd4
   } kind_type;

   typedef enum logic {
      ALU_ADD_LEASE = 1'b0,
      ALU_CMP_LEASE = 1'b1
   } alu_op_type;

endpackage

>>> hdl/lsbn_ram.sv
// ----------------------------------------------------------------------------
// lsbn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lsbn_alu.sv
// ----------------------------------------------------------------------------
// lsbn_alu
// Shared time adder: lease expiry sum and lease liveness compare.
// ----------------------------------------------------------------------------
module lsbn_alu #(
   parameter int TIME_BITS = lsbn_pkg::TIME_BITS_DEFAULT
) (
   input  lsbn_pkg::alu_op_type         op,
   input  logic [TIME_BITS-1:0]         now_val,
   input  logic [TIME_BITS-1:0]         lease_val,
   input  logic [lsbn_pkg::TICKS_W-1:0] ticks,
   output logic [TIME_BITS-1:0]         sum,
   output logic                         carry
);

   import lsbn_pkg::*;

   logic [TIME_BITS-1:0] operand_b;
   logic                 carry_in;
   logic [TIME_BITS:0]   total;

   // The compare forms now - lease; a carry out means now >= lease, so the
   // lease is no longer live. The add forms now + ticks; a carry out means
   // the expiry has run past the top of the time range.
   always_comb begin
      if (op == ALU_CMP_LEASE) begin
         operand_b = ~lease_val;
         carry_in  = 1'b1;
      end else begin
         operand_b = TIME_BITS'(ticks);
         carry_in  = 1'b0;
      end
      total = {1'b0, now_val} + {1'b0, operand_b} + (TIME_BITS + 1)'(carry_in);
   end

   assign sum   = total[TIME_BITS-1:0];
   assign carry = total[TIME_BITS];

endmodule

>>> hdl/lease_subscribe_broadcast_node.sv
// ----------------------------------------------------------------------------
// lease_subscribe_broadcast_node
// One node of a push / lazy-push broadcast with subscription leases.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                    Direction
//  req       req_valid, req_stall, req_action, ...    in  (one event)
//  rsp       rsp_valid, rsp_stall, rsp_kind, ...      out (one send each)
//  csr       csr_write_en, csr_index, csr_write_data  in  (register write)
//
// Each event passes a decode state and then one state per result; a neighbour
// walk also steps an address state over each slot scanned up to the last
// recipient, and the shared adder checks each recipient's lease behind its
// registered RAM read. The next event is taken once the sequencer is back in
// idle after the final result.
// Reset is synchronous with no clearing pass; an rsp stall holds the sequencer.
// ----------------------------------------------------------------------------
module lease_subscribe_broadcast_node #(
   parameter int PEER_SLOTS = lsbn_pkg::PEER_SLOTS_DEFAULT,
   parameter int TIME_BITS  = lsbn_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lsbn_pkg::ACTION_W-1:0]    req_action,
   input  logic [lsbn_pkg::SLOT_FIELD_W-1:0] req_peer_slot,
   input  logic                             req_is_neighbour,
   input  logic                             req_is_duplicate,
   input  logic                             req_start_with_body,
   input  logic [lsbn_pkg::NOW_W-1:0]       req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lsbn_pkg::KIND_W-1:0]      rsp_kind,
   output logic [lsbn_pkg::SLOT_FIELD_W-1:0] rsp_dest_peer,
   output logic                             rsp_last,
   input  logic                             csr_write_en,
   input  logic [lsbn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsbn_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import lsbn_pkg::*;

`include "lease_subscribe_broadcast_node_defines.svh"

   localparam int SLOT_W = $clog2(PEER_SLOTS);
   localparam int CMP_W  = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HEAD,
      ST_REQ,
      ST_WALK_ADDR,
      ST_WALK_EMIT
   } state_type;

   // Control and node state
   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         idx_ff, idx_in;
   logic                      skip_en_ff, skip_en_in;
   logic                      walk_en_ff, walk_en_in;
   logic                      do_req_ff, do_req_in;
   kind_type                  head_kind_ff, head_kind_in;
   logic                      prune_ff, prune_in;
   logic [TICKS_W-1:0]        ticks_ff, ticks_in;
   logic                      body_held_ff, body_held_in;
   logic                      first_seen_ff, first_seen_in;
   logic                      advert_ff, advert_in;
   logic [PEER_SLOTS-1:0]     lease_valid_ff, lease_valid_in;
   logic [PEER_SLOTS-1:0]     neigh_ff, neigh_in;
   logic [PEER_SLOTS-1:0]     req_mask_ff, req_mask_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Event and result payload
   action_type                act_ff, act_in;
   logic [SLOT_FIELD_W-1:0]   slot_ff, slot_in;
   logic                      nb_ff, nb_in;
   logic                      dup_ff, dup_in;
   logic                      swb_ff, swb_in;
   logic [TIME_BITS-1:0]      now_ff, now_in;
   kind_type                  rsp_kind_ff, rsp_kind_in;
   logic [SLOT_FIELD_W-1:0]   rsp_dest_ff, rsp_dest_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]          slot_ext;
   logic                      slot_ok;
   logic [SLOT_W-1:0]         slot_idx;
   logic [PEER_SLOTS-1:0]     slot_bit;
   logic [PEER_SLOTS-1:0]     eligible;
   logic [PEER_SLOTS-1:0]     above_idx;
   logic                      has_walk;
   logic                      more_after;
   logic                      cur_elig;
   logic                      out_free;
   logic                      accept;
   logic                      walk_next;

   alu_op_type                alu_op;
   logic [TIME_BITS-1:0]      alu_sum;
   logic                      alu_carry;
   logic                      ram_wr_en;
   logic [TIME_BITS-1:0]      ram_wr_data;
   logic [TIME_BITS-1:0]      ram_rd_data;
   logic                      lease_live;

   assign slot_ext  = CMP_W'(slot_ff);
   assign slot_ok   = slot_ext < CMP_W'(PEER_SLOTS);
   assign slot_idx  = slot_ext[SLOT_W-1:0];
   assign slot_bit  = PEER_SLOTS'(1) << slot_idx;
   assign eligible  = neigh_ff & ~(skip_en_ff ? slot_bit : '0);
   assign has_walk  = walk_en_ff && (|eligible);
   assign above_idx = ~((PEER_SLOTS'(2) << idx_ff) - PEER_SLOTS'(1));
   assign more_after = |(eligible & above_idx);
   assign cur_elig  = eligible[idx_ff];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign walk_next = has_walk;

   assign alu_op      = (state_ff == ST_EXEC) ? ALU_ADD_LEASE : ALU_CMP_LEASE;
   assign ram_wr_en   = (state_ff == ST_EXEC) && (act_ff == ACT_REQUEST) && slot_ok;
   assign ram_wr_data = alu_carry ? '1 : alu_sum;
   assign lease_live  = lease_valid_ff[idx_ff] && !alu_carry;

   lsbn_alu #(
      .TIME_BITS(TIME_BITS)
   ) u_alu (
      .op       (alu_op),
      .now_val  (now_ff),
      .lease_val(ram_rd_data),
      .ticks    (ticks_ff),
      .sum      (alu_sum),
      .carry    (alu_carry)
   );

   lsbn_ram #(
      .WIDTH(TIME_BITS),
      .DEPTH(PEER_SLOTS)
   ) u_lease_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(slot_idx),
      .wr_data(ram_wr_data),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      skip_en_in     = skip_en_ff;
      walk_en_in     = walk_en_ff;
      do_req_in      = do_req_ff;
      head_kind_in   = head_kind_ff;
      prune_in       = prune_ff;
      ticks_in       = ticks_ff;
      body_held_in   = body_held_ff;
      first_seen_in  = first_seen_ff;
      advert_in      = advert_ff;
      lease_valid_in = lease_valid_ff;
      neigh_in       = neigh_ff;
      req_mask_in    = req_mask_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      act_in         = act_ff;
      slot_in        = slot_ff;
      nb_in          = nb_ff;
      dup_in         = dup_ff;
      swb_in         = swb_ff;
      now_in         = now_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_PRUNE_ON_DUPLICATE: prune_in = csr_write_data[0];
            CSR_LEASE_TICKS:        ticks_in = csr_write_data[TICKS_W-1:0];
            default:                ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = action_type'(req_action);
               slot_in  = req_peer_slot;
               nb_in    = req_is_neighbour;
               dup_in   = req_is_duplicate;
               swb_in   = req_start_with_body;
               now_in   = TIME_BITS'(req_now_ms);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in   = ST_IDLE;
            do_req_in  = 1'b0;
            walk_en_in = 1'b0;
            skip_en_in = 1'b0;
            case (act_ff)
               ACT_PUBLISH, ACT_BODY_READY: begin
                  if (!body_held_ff) begin
                     body_held_in = 1'b1;
                     head_kind_in = KIND_DELIVER;
                     walk_en_in   = 1'b1;
                     state_in     = ST_HEAD;
                  end
               end
               ACT_PEER_UPSERT: begin
                  if (slot_ok) begin
                     neigh_in[slot_idx] = nb_ff;
                  end
               end
               ACT_PEER_REMOVE: begin
                  if (slot_ok) begin
                     neigh_in[slot_idx]       = 1'b0;
                     lease_valid_in[slot_idx] = 1'b0;
                  end
               end
               ACT_HAVE: begin
                  // Only the first advert of a round is answered.
                  if (slot_ok && !body_held_ff && !advert_ff) begin
                     advert_in = 1'b1;
                     if (!req_mask_ff[slot_idx]) begin
                        req_mask_in[slot_idx] = 1'b1;
                        head_kind_in          = KIND_REQUEST;
                        state_in              = ST_HEAD;
                     end
                  end
               end
               ACT_REQUEST: begin
                  if (slot_ok) begin
                     lease_valid_in[slot_idx] = 1'b1;
                     if (body_held_ff) begin
                        head_kind_in = KIND_PIECE;
                        state_in     = ST_HEAD;
                     end
                  end
               end
               ACT_PIECE: begin
                  if (slot_ok) begin
                     if (dup_ff || body_held_ff) begin
                        if (prune_ff) begin
                           head_kind_in = KIND_CANCEL;
                           state_in     = ST_HEAD;
                        end
                     end else begin
                        body_held_in = 1'b1;
                        head_kind_in = KIND_DELIVER;
                        walk_en_in   = 1'b1;
                        skip_en_in   = 1'b1;
                        state_in     = ST_HEAD;
                        if (!first_seen_ff) begin
                           first_seen_in = 1'b1;
                           if (!req_mask_ff[slot_idx]) begin
                              req_mask_in[slot_idx] = 1'b1;
                              do_req_in             = 1'b1;
                           end
                        end
                     end
                  end
               end
               ACT_CANCEL: begin
                  if (slot_ok && prune_ff) begin
                     lease_valid_in[slot_idx] = 1'b0;
                  end
               end
               ACT_NEW_ROUND: begin
                  body_held_in  = swb_ff;
                  first_seen_in = 1'b0;
                  advert_in     = 1'b0;
                  req_mask_in   = '0;
               end
               default: ;
            endcase
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = head_kind_ff;
               rsp_dest_in  = (head_kind_ff == KIND_DELIVER) ? '0 : slot_ff;
               rsp_last_in  = !do_req_ff && !walk_next;
               idx_in       = '0;
               if (do_req_ff) begin
                  state_in = ST_REQ;
               end else if (walk_next) begin
                  state_in = ST_WALK_ADDR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REQ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_REQUEST;
               rsp_dest_in  = slot_ff;
               rsp_last_in  = !walk_next;
               state_in     = walk_next ? ST_WALK_ADDR : ST_IDLE;
            end
         end
         ST_WALK_ADDR: begin
            // The RAM reads the expiry of idx_ff during this cycle.
            if (cur_elig) begin
               state_in = ST_WALK_EMIT;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_WALK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = lease_live ? KIND_PIECE : KIND_HAVE;
               rsp_dest_in  = SLOT_FIELD_W'(idx_ff);
               rsp_last_in  = !more_after;
               if (more_after) begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = ST_WALK_ADDR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         skip_en_ff     <= 1'b0;
         walk_en_ff     <= 1'b0;
         do_req_ff      <= 1'b0;
         head_kind_ff   <= KIND_DELIVER;
         prune_ff       <= 1'b0;
         ticks_ff       <= LEASE_TICKS_RESET;
         body_held_ff   <= 1'b0;
         first_seen_ff  <= 1'b0;
         advert_ff      <= 1'b0;
         lease_valid_ff <= '0;
         neigh_ff       <= '0;
         req_mask_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         skip_en_ff     <= skip_en_in;
         walk_en_ff     <= walk_en_in;
         do_req_ff      <= do_req_in;
         head_kind_ff   <= head_kind_in;
         prune_ff       <= prune_in;
         ticks_ff       <= ticks_in;
         body_held_ff   <= body_held_in;
         first_seen_ff  <= first_seen_in;
         advert_ff      <= advert_in;
         lease_valid_ff <= lease_valid_in;
         neigh_ff       <= neigh_in;
         req_mask_ff    <= req_mask_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      act_ff      <= act_in;
      slot_ff     <= slot_in;
      nb_ff       <= nb_in;
      dup_ff      <= dup_in;
      swb_ff      <= swb_in;
      now_ff      <= now_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_dest_ff <= rsp_dest_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_dest_peer = rsp_dest_ff;
   assign rsp_last      = rsp_last_ff;

   `LSBN_ASSERT_SAME(a_walk_to_neighbour, clock, reset,
      (state_ff == ST_WALK_EMIT) && out_free, neigh_ff[idx_ff],
      "walk emitted a send to a slot that is not a neighbour")

   `LSBN_ASSERT_NEXT(a_last_ends_item, clock, reset,
      (state_ff != ST_IDLE) && (state_ff != ST_EXEC) && out_free && rsp_last_in
         && (state_ff != ST_WALK_ADDR),
      state_ff == ST_IDLE,
      "sequencer kept running after the final result of an event")

   `LSBN_ASSERT_SAME(a_deliver_holds_body, clock, reset,
      (state_ff == ST_HEAD) && (head_kind_ff == KIND_DELIVER), body_held_ff,
      "body delivered without the body being marked as held")

   `LSBN_ASSERT_SAME(a_request_marked, clock, reset,
      (state_ff == ST_REQ) || ((state_ff == ST_HEAD) && (head_kind_ff == KIND_REQUEST)),
      req_mask_ff[slot_idx],
      "request sent to a slot not marked in the request mask")

endmodule

>>> verif/tb_lease_subscribe_broadcast_node.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for lease_subscribe_broadcast_node
// Drives broadcast events into the node, predicts every send it should emit
// (deliver, piece, have, request, cancel) and checks each send transfer in
// order, under random sender gaps, receiver stalls and long hold-offs.
// ----------------------------------------------------------------------------
module tb_lease_subscribe_broadcast_node;
   import lsbn_pkg::*;

   localparam int PEER_SLOTS = PEER_SLOTS_DEFAULT;
   localparam logic [NOW_W-1:0] TIME_TOP = '1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_TOP = 4'd15;
   localparam int QUIET_CYCLES = 40;
   localparam int unsigned RUN_LIMIT_NS = 15_000_000;

   typedef struct {
      logic [ACTION_W-1:0]     action;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    neighbour;
      logic                    duplicate;
      logic                    with_body;
      logic [NOW_W-1:0]        now;
   } node_event_type;

   typedef struct {
      kind_type                kind;
      logic [SLOT_FIELD_W-1:0] dest;
      logic                    last;
   } send_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action = '0;
   logic [SLOT_FIELD_W-1:0] req_peer_slot = '0;
   logic                    req_is_neighbour = 1'b0;
   logic                    req_is_duplicate = 1'b0;
   logic                    req_start_with_body = 1'b0;
   logic [NOW_W-1:0]        req_now_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [KIND_W-1:0]       rsp_kind;
   logic [SLOT_FIELD_W-1:0] rsp_dest_peer;
   logic                    rsp_last;
   logic                    csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // Predicted node state and register copies.
   logic                    holds_body = 1'b0;
   logic [PEER_SLOTS-1:0]   lease_on = '0;
   logic [NOW_W-1:0]        lease_expiry [PEER_SLOTS];
   logic [PEER_SLOTS-1:0]   neighbour_on = '0;
   logic                    fresh_sender_seen = 1'b0;
   logic                    advert_taken = 1'b0;
   logic [PEER_SLOTS-1:0]   requested_mask = '0;
   logic                    prune_en = 1'b0;
   logic [TICKS_W-1:0]      lease_len = LEASE_TICKS_RESET;

   send_type pending_sends [$];
   send_type batch [$];

   logic [NOW_W-1:0] wall_ms = '0;
   bit    wall_moves = 1'b0;
   int    gap_max = 0;
   int    burst_left = 1;

   // Receiver pacing; the test posts hold-off orders, the pacing process counts them.
   bit    stall_on = 1'b0;
   int    hold_order_cycles = 0;
   int    hold_order_seq = 0;
   int    hold_seq_seen = 0;
   int    hold_left = 0;
   int    stall_run = 0;
   int    flow_run = 0;

   int    fail_count = 0;
   int    events_accepted = 0;
   int    sends_checked = 0;
   int    kind_tally [5] = '{default: 0};

   lease_subscribe_broadcast_node DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_peer_slot       (req_peer_slot),
      .req_is_neighbour    (req_is_neighbour),
      .req_is_duplicate    (req_is_duplicate),
      .req_start_with_body (req_start_with_body),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_dest_peer       (rsp_dest_peer),
      .rsp_last            (rsp_last),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_order_seq != hold_seq_seen) begin
         hold_seq_seen = hold_order_seq;
         hold_left = hold_order_cycles;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (flow_run > 0) begin
         flow_run = flow_run - 1;
         rsp_stall <= 1'b0;
      end else begin
         stall_run = $urandom_range(0, 6);
         flow_run = $urandom_range(0, 10);
         rsp_stall <= 1'b0;
      end
   end

   // Each send transfer is matched against the oldest predicted send.
   always @(posedge clock) begin
      send_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_sends.size() == 0) begin
            $error("unexpected send: kind %0d dest_peer %0d last %0d",
                   rsp_kind, rsp_dest_peer, rsp_last);
            fail_count++;
         end else begin
            want = pending_sends.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_dest_peer !== want.dest) begin
               $error("dest_peer: expected %0d, actual %0d", want.dest, rsp_dest_peer);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
            sends_checked++;
            kind_tally[want.kind]++;
         end
      end
   end

   function automatic logic coin();
      return 1'($urandom);
   endfunction

   function automatic logic [SLOT_FIELD_W-1:0] rnd_slot();
      return SLOT_FIELD_W'($urandom);
   endfunction

   function automatic void note_send(input kind_type kind, input logic [SLOT_FIELD_W-1:0] dest);
      send_type s;
      s.kind = kind;
      s.dest = dest;
      s.last = 1'b0;
      batch.push_back(s);
   endfunction

   function automatic void request_once(input logic [SLOT_FIELD_W-1:0] slot);
      if (!requested_mask[slot]) begin
         requested_mask[slot] = 1'b1;
         note_send(KIND_REQUEST, slot);
      end
   endfunction

   // Neighbours in slot order: a live lease gets the piece, the rest an advert.
   function automatic void walk_neighbours(input logic skip, input logic [SLOT_FIELD_W-1:0] sender,
                                           input logic [NOW_W-1:0] now);
      for (int s = 0; s < PEER_SLOTS; s++) begin
         if (neighbour_on[s] && !(skip && SLOT_FIELD_W'(s) == sender))
            note_send((lease_on[s] && lease_expiry[s] > now) ? KIND_PIECE : KIND_HAVE,
                      SLOT_FIELD_W'(s));
      end
   endfunction

   function automatic void predict_sends(input node_event_type ev);
      send_type final_send;
      batch.delete();
      case (ev.action)
         ACT_PUBLISH, ACT_BODY_READY: begin
            if (!holds_body) begin
               holds_body = 1'b1;
               note_send(KIND_DELIVER, '0);
               walk_neighbours(1'b0, '0, ev.now);
            end
         end
         ACT_PEER_UPSERT: neighbour_on[ev.slot] = ev.neighbour;
         ACT_PEER_REMOVE: begin
            neighbour_on[ev.slot] = 1'b0;
            lease_on[ev.slot] = 1'b0;
         end
         ACT_HAVE: begin
            if (!holds_body && !advert_taken) begin
               advert_taken = 1'b1;
               request_once(ev.slot);
            end
         end
         ACT_REQUEST: begin
            // Expiry saturates at the top of the time range.
            lease_expiry[ev.slot] = (ev.now > TIME_TOP - lease_len) ? TIME_TOP
                                                                    : ev.now + lease_len;
            lease_on[ev.slot] = 1'b1;
            if (holds_body)
               note_send(KIND_PIECE, ev.slot);
         end
         ACT_PIECE: begin
            if (ev.duplicate || holds_body) begin
               if (prune_en)
                  note_send(KIND_CANCEL, ev.slot);
            end else begin
               holds_body = 1'b1;
               note_send(KIND_DELIVER, '0);
               if (!fresh_sender_seen) begin
                  fresh_sender_seen = 1'b1;
                  request_once(ev.slot);
               end
               walk_neighbours(1'b1, ev.slot, ev.now);
            end
         end
         ACT_CANCEL: begin
            if (prune_en)
               lease_on[ev.slot] = 1'b0;
         end
         ACT_NEW_ROUND: begin
            holds_body = ev.with_body;
            fresh_sender_seen = 1'b0;
            advert_taken = 1'b0;
            requested_mask = '0;
         end
         default: ;
      endcase
      if (batch.size() > 0) begin
         final_send = batch.pop_back();
         final_send.last = 1'b1;
         batch.push_back(final_send);
      end
      foreach (batch[i])
         pending_sends.push_back(batch[i]);
   endfunction

   // Offers one event and returns once it has been transferred. The valid stays
   // high into the next event unless the burst ends here with a nonzero gap.
   task automatic send_event(input logic [ACTION_W-1:0] action,
                             input logic [SLOT_FIELD_W-1:0] slot,
                             input logic nb, input logic dup, input logic swb);
      node_event_type ev;
      int gap;
      if (wall_moves) begin
         case ($urandom_range(0, 9))
            0: wall_ms = $urandom;
            1: wall_ms = TIME_TOP - NOW_W'($urandom_range(0, 70000));
            2, 3: ;
            default: wall_ms = wall_ms + NOW_W'($urandom_range(1, 2 * int'(lease_len)));
         endcase
      end
      ev.action = action;
      ev.slot = slot;
      ev.neighbour = nb;
      ev.duplicate = dup;
      ev.with_body = swb;
      ev.now = wall_ms;
      req_valid <= 1'b1;
      req_action <= action;
      req_peer_slot <= slot;
      req_is_neighbour <= nb;
      req_is_duplicate <= dup;
      req_start_with_body <= swb;
      req_now_ms <= wall_ms;
      do @(posedge clock); while (req_stall !== 1'b0);
      events_accepted++;
      predict_sends(ev);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sends.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (index == CSR_PRUNE_ON_DUPLICATE)
         prune_en = data[0];
      else
         lease_len = data;
   endtask

   task automatic set_config(input logic prune, input logic [TICKS_W-1:0] ticks);
      write_csr(CSR_PRUNE_ON_DUPLICATE, (CSR_DATA_W'($urandom) & 16'hFFFE) | CSR_DATA_W'(prune));
      write_csr(CSR_LEASE_TICKS, ticks);
   endtask

   // Called only while the request valid is low.
   task automatic set_receiver(input bit stalls, input int hold);
      @(negedge clock);
      stall_on = stalls;
      if (hold > 0) begin
         hold_order_cycles = hold;
         hold_order_seq++;
      end
      @(posedge clock);
   endtask

   task automatic test_directed_defaults();
      wall_moves = 1'b0;
      wall_ms = '0;
      send_event(ACT_PEER_UPSERT, 4'd0, 1'b1, 1'b0, 1'b0);
      send_event(ACT_PEER_UPSERT, 4'd15, 1'b1, 1'b0, 1'b0);
      send_event(ACT_PEER_UPSERT, 4'd7, 1'b1, 1'b0, 1'b0);
      send_event(ACT_PEER_UPSERT, 4'd7, 1'b0, 1'b1, 1'b1);
      wall_ms = 32'hFFFF_FFF0;
      send_event(ACT_REQUEST, 4'd15, 1'b0, 1'b0, 1'b0);
      send_event(ACT_HAVE, 4'd3, 1'b0, 1'b0, 1'b0);
      send_event(ACT_HAVE, 4'd4, 1'b0, 1'b0, 1'b0);
      wall_ms = 32'hFFFF_FFFE;
      send_event(ACT_PIECE, 4'd5, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PIECE, 4'd0, 1'b0, 1'b1, 1'b0);
      send_event(ACT_REQUEST, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PUBLISH, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_BODY_READY, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_CANCEL, 4'd15, 1'b0, 1'b0, 1'b0);
      send_event(ACT_TIMER, 4'd9, 1'b1, 1'b1, 1'b1);
      send_event(ACT_UNUSED_TOP, 4'd15, 1'b1, 1'b1, 1'b1);
      wall_ms = 32'd100;
      send_event(ACT_REQUEST, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      wall_ms = 32'd10099;
      send_event(ACT_PUBLISH, 4'd0, 1'b0, 1'b0, 1'b0);
      // One tick later the lease of slot 0 has run out exactly.
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      wall_ms = 32'd10100;
      send_event(ACT_BODY_READY, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b1);
      send_event(ACT_HAVE, 4'd2, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PIECE, 4'd2, 1'b0, 1'b0, 1'b0);
      // The advertiser later sends the piece itself; its request is not repeated.
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_HAVE, 4'd3, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PIECE, 4'd3, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PEER_REMOVE, 4'd15, 1'b0, 1'b0, 1'b0);
      wait_quiet();
   endtask

   task automatic test_pruning_and_lease_extremes();
      wall_moves = 1'b0;
      set_config(1'b1, 16'd1);
      wall_ms = 32'd500;
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PEER_UPSERT, 4'd1, 1'b1, 1'b0, 1'b0);
      send_event(ACT_REQUEST, 4'd1, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PUBLISH, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PIECE, 4'd2, 1'b0, 1'b1, 1'b0);
      send_event(ACT_PIECE, 4'd1, 1'b0, 1'b0, 1'b0);
      send_event(ACT_CANCEL, 4'd1, 1'b0, 1'b0, 1'b0);
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_BODY_READY, 4'd0, 1'b0, 1'b0, 1'b0);
      wait_quiet();
      set_config(1'b1, 16'hFFFF);
      wall_ms = 32'hFFFF_0000;
      send_event(ACT_REQUEST, 4'd1, 1'b0, 1'b0, 1'b0);
      wall_ms = 32'hFFFF_0001;
      send_event(ACT_REQUEST, 4'd2, 1'b0, 1'b0, 1'b0);
      send_event(ACT_NEW_ROUND, 4'd0, 1'b0, 1'b0, 1'b0);
      send_event(ACT_PEER_UPSERT, 4'd2, 1'b1, 1'b0, 1'b0);
      wall_ms = 32'hFFFF_FFFE;
      send_event(ACT_PUBLISH, 4'd0, 1'b0, 1'b0, 1'b0);
      wait_quiet();
   endtask

   // One broadcast round: subscriptions, adverts, the body, then stragglers.
   task automatic run_round();
      logic [SLOT_FIELD_W-1:0] advertiser;
      advertiser = rnd_slot();
      send_event(ACT_NEW_ROUND, rnd_slot(), coin(), coin(), $urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 3))
         send_event(ACT_PEER_UPSERT, rnd_slot(), $urandom_range(0, 4) != 0, coin(), coin());
      repeat ($urandom_range(0, 2))
         send_event(ACT_REQUEST, rnd_slot(), coin(), coin(), coin());
      if (coin())
         send_event(ACT_HAVE, advertiser, coin(), coin(), coin());
      repeat ($urandom_range(0, 2))
         send_event(ACT_HAVE, rnd_slot(), coin(), coin(), coin());
      case ($urandom_range(0, 3))
         0: send_event(ACT_PUBLISH, rnd_slot(), coin(), coin(), coin());
         1: send_event(ACT_BODY_READY, rnd_slot(), coin(), coin(), coin());
         default: send_event(ACT_PIECE, coin() ? advertiser : rnd_slot(), coin(), 1'b0, coin());
      endcase
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 6))
            0: send_event(ACT_PIECE, rnd_slot(), coin(), coin(), coin());
            1: send_event(ACT_REQUEST, rnd_slot(), coin(), coin(), coin());
            2: send_event(ACT_CANCEL, rnd_slot(), coin(), coin(), coin());
            3: send_event(ACT_HAVE, rnd_slot(), coin(), coin(), coin());
            4: send_event(ACT_PEER_REMOVE, rnd_slot(), coin(), coin(), coin());
            5: send_event(ACT_PEER_UPSERT, rnd_slot(), coin(), coin(), coin());
            default: send_event(ACT_TIMER, rnd_slot(), coin(), coin(), coin());
         endcase
      end
   endtask

   task automatic test_random_rounds(input logic prune, input logic [TICKS_W-1:0] ticks,
                                     input int rounds);
      wall_moves = 1'b1;
      set_config(prune, ticks);
      repeat (rounds) run_round();
      wait_quiet();
   endtask

   task automatic test_backpressure();
      wall_moves = 1'b1;
      gap_max = 0;
      set_receiver(1'b1, 0);
      for (int s = 0; s < 12; s++)
         send_event(ACT_PEER_UPSERT, SLOT_FIELD_W'(s), 1'b1, coin(), coin());
      send_event(ACT_NEW_ROUND, rnd_slot(), coin(), coin(), 1'b0);
      wait_quiet();
      // The receiver holds off while events keep coming, so the node backs up.
      set_receiver(1'b1, 400);
      send_event(ACT_PUBLISH, rnd_slot(), coin(), coin(), coin());
      repeat (3) begin
         send_event(ACT_NEW_ROUND, rnd_slot(), coin(), coin(), 1'b0);
         send_event(ACT_PIECE, rnd_slot(), coin(), 1'b0, coin());
         send_event(ACT_REQUEST, rnd_slot(), coin(), coin(), coin());
      end
      wait_quiet();
      set_receiver(1'b0, 250);
      repeat (4) begin
         send_event(ACT_NEW_ROUND, rnd_slot(), coin(), coin(), 1'b0);
         send_event(ACT_BODY_READY, rnd_slot(), coin(), coin(), coin());
      end
      wait_quiet();
   endtask

   task automatic test_noise(input int count);
      wall_moves = 1'b1;
      gap_max = 8;
      set_receiver(1'b1, 0);
      set_config(coin(), TICKS_W'($urandom_range(1, 65535)));
      repeat (count)
         send_event(ACTION_W'($urandom), rnd_slot(), coin(), coin(), coin());
      wait_quiet();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_pruning_and_lease_extremes();

      gap_max = 0;
      set_receiver(1'b0, 0);
      test_random_rounds(1'b0, LEASE_TICKS_RESET, 10);
      gap_max = 6;
      set_receiver(1'b1, 0);
      test_random_rounds(1'b1, 16'd1, 10);
      gap_max = 20;
      set_receiver(1'b0, 0);
      test_random_rounds(1'b1, 16'hFFFF, 10);
      gap_max = 4;
      set_receiver(1'b1, 0);
      test_random_rounds(1'b0, TICKS_W'($urandom_range(1, 65535)), 12);

      test_backpressure();
      test_noise(60);

      $display("Run covered %0d events over directed cases, gossip rounds, hold-offs and noise.",
               events_accepted);
      $display("Checked %0d sends: deliver %0d, piece %0d, have %0d, request %0d, cancel %0d.",
               sends_checked, kind_tally[KIND_DELIVER], kind_tally[KIND_PIECE],
               kind_tally[KIND_HAVE], kind_tally[KIND_REQUEST], kind_tally[KIND_CANCEL]);
      if (fail_count == 0)
         $display("lease_subscribe_broadcast_node: match");
      else
         $display("lease_subscribe_broadcast_node: mismatch");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("lease_subscribe_broadcast_node: mismatch");
      $finish;
   end

endmodule
